// ===== hdl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

   localparam int OPCODE_W = 1;
   localparam int CHAR_W = 8;
   localparam int INDEX_W = 11;
   localparam int COL_W = 7;
   localparam int ROW_W = 5;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;

   localparam logic [OPCODE_W-1:0] OP_PUT = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

   localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'd10;
   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
   localparam logic [ATTR_W-1:0] RESET_ATTRIBUTE = 8'h07;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/tcw_if.sv =====
`default_nettype none

interface tcw_req_if;
   import tcw_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [CHAR_W-1:0]   char_code;
   logic [INDEX_W-1:0]  cell_index;

   modport source (output valid, output opcode, output char_code, output cell_index,
                   input ready);
   modport sink (input valid, input opcode, input char_code, input cell_index,
                 output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;

   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  cursor_col;
   logic [ROW_W-1:0]  cursor_row;
   logic [CELL_W-1:0] cell_value;

   modport source (output valid, output cursor_col, output cursor_row, output cell_value,
                   input ready);
   modport sink (input valid, input cursor_col, input cursor_row, input cell_value,
                 output ready);
endinterface

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
// put: result registered on the following cycle; one put a cycle while results are taken and no scroll runs
// read: result from the screen memory read register mem_rd_ff registered in ST_READ; no new word until ST_IDLE
// scroll: a put past the last row holds ready low through ST_COPY and ST_DRAIN while the
//   simple dual-port screen memory is copied up one row and the bottom row blanked, one cell a cycle
// reset: synchronous; a clearing pass (ST_CLEAR) fills the screen with blank
//   cells before the first word is accepted; cursor 0,0 and attribute 0x07
`default_nettype none

module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25
) (
   input  wire                     clock,
   input  wire                     reset,
   tcw_req_if.sink                 req_if,
   tcw_rsp_if.source               rsp_if,
   input  wire                     csr_write_enable,
   input  wire [tcw_pkg::ATTR_W-1:0] csr_write_data
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int AW = $clog2(CELL_COUNT);
   localparam int SW = $clog2(CELL_COUNT + COLUMNS);
   localparam int CW = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
   localparam int RW = (ROWS > 2) ? $clog2(ROWS) : 1;

   logic [CELL_W-1:0] mem [CELL_COUNT];
   logic [CELL_W-1:0] mem_rd_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;

   state_type         state_ff, state_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [SW-1:0]     ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic              pend_blank_ff, pend_blank_in;
   logic [AW-1:0]     dst_ff, dst_in;
   logic [ATTR_W-1:0] attr_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;

   logic accept;
   logic is_put;
   logic is_newline;
   logic idx_ok;
   logic next_row;
   logic scroll;

   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept = req_if.valid && req_if.ready;
   assign is_put = (req_if.opcode == OP_PUT);
   assign is_newline = (req_if.char_code == NEWLINE_BYTE);
   assign idx_ok = (32'(req_if.cell_index) < CELL_COUNT);
   assign next_row = is_newline || (col_ff == CW'(COLUMNS - 1));
   assign scroll = next_row && (row_ff == RW'(ROWS - 1));

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.cursor_col = rsp_col_ff;
   assign rsp_if.cursor_row = rsp_row_ff;
   assign rsp_if.cell_value = rsp_cell_ff;

   // screen memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_raddr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == SW'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (is_put) begin
                  if (scroll) begin
                     state_in = ST_COPY;
                  end
               end else if (idx_ok) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_COPY: begin
            if (ptr_ff == SW'(CELL_COUNT + COLUMNS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      pos_in = pos_ff;
      ptr_in = ptr_ff;
      pend_in = 1'b0;
      pend_blank_in = 1'b0;
      dst_in = AW'(ptr_ff - SW'(COLUMNS));
      mem_we = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = {attr_ff, req_if.char_code};
      mem_raddr = AW'(req_if.cell_index);
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_col_in = rsp_col_ff;
      rsp_row_in = rsp_row_ff;
      rsp_cell_in = rsp_cell_ff;

      if (pend_ff) begin
         mem_we = 1'b1;
         mem_waddr = dst_ff;
         mem_wdata = pend_blank_ff ? BLANK_CELL : mem_rd_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = AW'(ptr_ff);
            mem_wdata = BLANK_CELL;
            ptr_in = ptr_ff + SW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               if (is_put) begin
                  mem_we = !is_newline;
                  if (next_row) begin
                     col_in = '0;
                     if (scroll) begin
                        row_in = RW'(ROWS - 1);
                        pos_in = AW'((ROWS - 1) * COLUMNS);
                        ptr_in = SW'(COLUMNS);
                     end else begin
                        row_in = row_ff + RW'(1);
                        pos_in = pos_ff + AW'(COLUMNS) - AW'(col_ff);
                     end
                  end else begin
                     col_in = col_ff + CW'(1);
                     pos_in = pos_ff + AW'(1);
                  end
                  rsp_valid_in = 1'b1;
                  rsp_col_in = COL_W'(col_in);
                  rsp_row_in = ROW_W'(row_in);
                  rsp_cell_in = '0;
               end else if (!idx_ok) begin
                  rsp_valid_in = 1'b1;
                  rsp_col_in = COL_W'(col_ff);
                  rsp_row_in = ROW_W'(row_ff);
                  rsp_cell_in = '0;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_col_in = COL_W'(col_ff);
            rsp_row_in = ROW_W'(row_ff);
            rsp_cell_in = mem_rd_ff;
         end
         ST_COPY: begin
            mem_raddr = AW'(ptr_ff);
            pend_in = 1'b1;
            pend_blank_in = (ptr_ff >= SW'(CELL_COUNT));
            ptr_in = ptr_ff + SW'(1);
         end
         ST_DRAIN: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         col_ff <= '0;
         row_ff <= '0;
         pos_ff <= '0;
         ptr_ff <= '0;
         pend_ff <= 1'b0;
         attr_ff <= RESET_ATTRIBUTE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         row_ff <= row_in;
         pos_ff <= pos_in;
         ptr_ff <= ptr_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            attr_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_blank_ff <= pend_blank_in;
      dst_ff <= dst_in;
      rsp_col_ff <= rsp_col_in;
      rsp_row_ff <= rsp_row_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   // cursor position register tracks row and column
   a_pos_match: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) == 32'(row_ff) * COLUMNS + 32'(col_ff))
      else $error("cursor position out of step with row and column");

   // cursor sits at the start of the last row during a scroll
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (row_ff == RW'(ROWS - 1)) && (col_ff == '0))
      else $error("cursor not on last row during scroll");

   // every screen write lands inside the buffer
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_waddr) < CELL_COUNT))
      else $error("screen write outside buffer");

   // a scroll ends with the bottom row blanking drained
   a_drain_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> pend_ff && pend_blank_ff)
      else $error("scroll drain without pending blank write");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
   import tcw_pkg::*;

   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;
   localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
   localparam int TOTAL_WORDS = 850;
   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int DRAIN_CYCLES = SCREEN_CELLS + 100;

   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [CELL_W-1:0] cell_val;
   } console_result_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [ATTR_W-1:0] csr_write_data;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   text_console_writer #(
      .COLUMNS(SCREEN_COLS),
      .ROWS(SCREEN_ROWS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // screen predictor state
   logic [CELL_W-1:0] console_screen [SCREEN_CELLS];
   int unsigned console_col;
   int unsigned console_row;
   logic [ATTR_W-1:0] console_attr;

   console_result_type pending_results [$];

   int unsigned cycle_count;
   int unsigned words_sent;
   int unsigned puts_seen;
   int unsigned reads_seen;
   int unsigned scrolls_seen;
   int unsigned attr_writes;
   int unsigned results_checked;
   int unsigned mismatches;
   int unsigned unexpected_results;

   // sender and receiver pacing
   bit gaps_enabled;
   int unsigned burst_left;
   int unsigned stall_style;
   int unsigned hold_request;
   int unsigned holdoff_left;
   logic [15:0] ready_pattern;
   logic [3:0] pattern_age;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic console_result_type predict_console(logic [OPCODE_W-1:0] op,
                                                         logic [CHAR_W-1:0] ch,
                                                         logic [INDEX_W-1:0] idx);
      console_result_type res;
      int unsigned pos;
      res.cell_val = '0;
      if (op == OP_PUT) begin
         puts_seen++;
         if (ch == NEWLINE_BYTE) begin
            console_col = 0;
            console_row++;
         end else begin
            pos = console_row * SCREEN_COLS + console_col;
            if (pos < SCREEN_CELLS) console_screen[pos] = {console_attr, ch};
            console_col++;
         end
         if (console_col >= SCREEN_COLS) begin
            console_col = 0;
            console_row++;
         end
         if (console_row >= SCREEN_ROWS) begin
            scrolls_seen++;
            for (int i = 0; i < SCREEN_COLS * (SCREEN_ROWS - 1); i++)
               console_screen[i] = console_screen[i + SCREEN_COLS];
            for (int i = SCREEN_COLS * (SCREEN_ROWS - 1); i < SCREEN_CELLS; i++)
               console_screen[i] = BLANK_CELL;
            console_row = SCREEN_ROWS - 1;
         end
      end else begin
         reads_seen++;
         if (idx < SCREEN_CELLS) res.cell_val = console_screen[idx];
      end
      res.col = console_col[COL_W-1:0];
      res.row = console_row[ROW_W-1:0];
      return res;
   endfunction

   // accepted words feed the predictor, accepted results are checked in order
   always @(posedge clock) begin
      console_result_type got;
      console_result_type want;
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
         pending_results.push_back(predict_console(req_bus.opcode, req_bus.char_code,
                                                   req_bus.cell_index));
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.col = rsp_bus.cursor_col;
         got.row = rsp_bus.cursor_row;
         got.cell_val = rsp_bus.cell_value;
         if (pending_results.size() == 0) begin
            unexpected_results++;
            $display("unexpected result col=%0d row=%0d cell=%h", got.col, got.row,
                     got.cell_val);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected col=%0d row=%0d cell=%h,",
                           want.col, want.row, want.cell_val,
                           " got col=%0d row=%0d cell=%h",
                           got.col, got.row, got.cell_val);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // receiver: plain, patterned stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_request != 0) begin
         holdoff_left = hold_request;
         hold_request = 0;
      end
      if (holdoff_left > 0) begin
         rsp_bus.ready <= 1'b0;
         holdoff_left--;
      end else if (stall_style == 0) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         if (pattern_age == 0) ready_pattern = 16'($urandom_range(1, 16'hFFFF));
         rsp_bus.ready <= ready_pattern[pattern_age];
         pattern_age = pattern_age + 1'b1;
      end
   end

   task automatic send_word(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                            logic [INDEX_W-1:0] idx);
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.char_code <= ch;
      req_bus.cell_index <= idx;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_item(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                            logic [INDEX_W-1:0] idx);
      int unsigned gap;
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
      end
      send_word(op, ch, idx);
   endtask

   task automatic put_char(logic [CHAR_W-1:0] ch);
      send_item(OP_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
   endtask

   task automatic read_cell(logic [INDEX_W-1:0] idx);
      send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), idx);
   endtask

   function automatic logic [CHAR_W-1:0] text_char();
      logic [CHAR_W-1:0] ch;
      do ch = CHAR_W'($urandom_range(0, 255)); while (ch == NEWLINE_BYTE);
      return ch;
   endfunction

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_attribute(logic [ATTR_W-1:0] value);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data <= ATTR_W'($urandom_range(0, 255));
      console_attr = value;
      attr_writes++;
   endtask

   task automatic test_blank_screen();
      read_cell(INDEX_W'(0));
      read_cell(INDEX_W'(SCREEN_COLS - 1));
      read_cell(INDEX_W'(SCREEN_CELLS - SCREEN_COLS));
      read_cell(INDEX_W'(SCREEN_CELLS - 1));
      read_cell(INDEX_W'(SCREEN_CELLS));
      read_cell(11'h7FF);
   endtask

   task automatic test_put_extremes();
      // null byte, all ones and a format character are stored as they are
      put_char(8'h00);
      put_char(8'hFF);
      put_char(8'h25);
      put_char(8'h73);
      put_char(8'h41);
      for (int i = 0; i < 5; i++) read_cell(INDEX_W'(i));
      put_char(NEWLINE_BYTE);
      put_char(8'h7F);
      read_cell(INDEX_W'(SCREEN_COLS));
      read_cell(INDEX_W'(SCREEN_COLS + 1));
      read_cell(11'h400);
   endtask

   task automatic test_attribute_register();
      logic [ATTR_W-1:0] attr_values [4];
      int unsigned pos;
      attr_values = '{8'h00, 8'hFF, 8'hA5, ATTR_W'($urandom_range(0, 255))};
      foreach (attr_values[k]) begin
         write_attribute(attr_values[k]);
         pos = console_row * SCREEN_COLS + console_col;
         repeat (3) put_char(text_char());
         for (int i = 0; i < 3; i++)
            read_cell(INDEX_W'((pos + i) % SCREEN_CELLS));
      end
   endtask

   task automatic test_wrap_and_scroll();
      int unsigned line_len;
      gaps_enabled = 1;
      // short lines until the screen has scrolled a few times
      for (int r = 0; r < SCREEN_ROWS + 3; r++) begin
         line_len = $urandom_range(1, 4);
         repeat (line_len) put_char(text_char());
         put_char(NEWLINE_BYTE);
      end
      // a full bottom line wraps past the last column and scrolls
      repeat (SCREEN_COLS) put_char(text_char());
      for (int i = 0; i < 4; i++) begin
         read_cell(INDEX_W'(SCREEN_CELLS - 2 * SCREEN_COLS + i));
         read_cell(INDEX_W'(SCREEN_CELLS - SCREEN_COLS + i * 26));
      end
      read_cell(INDEX_W'(SCREEN_CELLS - SCREEN_COLS - 1));
      read_cell(INDEX_W'(0));
      read_cell(INDEX_W'(SCREEN_COLS));
      // newline on the last row
      put_char(NEWLINE_BYTE);
      read_cell(INDEX_W'(SCREEN_CELLS - 2 * SCREEN_COLS));
   endtask

   task automatic test_backpressure();
      wait_drained();
      @(posedge clock);
      hold_request = 300;
      @(negedge clock);
      gaps_enabled = 0;
      for (int i = 0; i < 40; i++) begin
         if (i % 5 == 4) read_cell(INDEX_W'($urandom_range(0, SCREEN_CELLS - 1)));
         else put_char(text_char());
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int unsigned phase_left;
      int unsigned pick;
      int unsigned row_pick;
      phase_left = 0;
      while (words_sent < TOTAL_WORDS) begin
         if (phase_left == 0) begin
            pick = $urandom_range(0, 3);
            write_attribute(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF :
                            ATTR_W'($urandom_range(0, 255)));
            gaps_enabled = $urandom_range(0, 2) != 0;
            stall_style = $urandom_range(0, 2) != 0;
            phase_left = $urandom_range(80, 140);
         end
         phase_left--;
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            put_char(NEWLINE_BYTE);
         end else if (pick < 65) begin
            put_char(CHAR_W'($urandom_range(0, 255)));
         end else if (pick < 90) begin
            // mostly near the cursor so recent writes get read back
            row_pick = console_row > 0 ? console_row - $urandom_range(0, 1) : 0;
            read_cell(INDEX_W'(row_pick * SCREEN_COLS + $urandom_range(0, SCREEN_COLS - 1)));
         end else if (pick < 96) begin
            read_cell(INDEX_W'($urandom_range(0, SCREEN_CELLS - 1)));
         end else begin
            read_cell(INDEX_W'($urandom_range(SCREEN_CELLS, 2047)));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_PUT;
      req_bus.char_code = '0;
      req_bus.cell_index = '0;
      rsp_bus.ready = 1'b0;
      hold_request = 0;
      holdoff_left = 0;
      stall_style = 0;
      pattern_age = '0;
      ready_pattern = '1;
      gaps_enabled = 0;
      burst_left = 0;
      for (int i = 0; i < SCREEN_CELLS; i++) console_screen[i] = BLANK_CELL;
      console_col = 0;
      console_row = 0;
      console_attr = RESET_ATTRIBUTE;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_blank_screen();
      test_put_extremes();
      stall_style = 1;
      test_attribute_register();
      test_wrap_and_scroll();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d words (%0d puts, %0d reads), %0d scrolls, %0d attribute writes",
               words_sent, puts_seen, reads_seen, scrolls_seen, attr_writes);
      $display("%0d results checked, %0d mismatches, %0d unexpected, %0d outstanding",
               results_checked, mismatches, unexpected_results, pending_results.size());
      if (mismatches == 0 && unexpected_results == 0 && pending_results.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
